// ===== sv/cdao_pkg.sv =====
// Package for calendar_date_add_offset: sequencer states, calendar constants
// and the month length lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdao_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVM,
    ST_DIVY,
    ST_YEARS,
    ST_MONTHS,
    ST_DONE
  } state_e;

  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned LeapCycle     = 400;
  localparam int unsigned DaysPerYear   = 365;
  localparam logic [3:0]  MonthJan      = 4'd1;
  localparam logic [3:0]  MonthFeb      = 4'd2;
  localparam logic [3:0]  MonthDec      = 4'd12;

  // Month quotient of (start_month + add_months - 1) / 12 fits in 9 bits,
  // year / 400 in 7 bits; steps are counted from the top bit down.
  localparam logic [3:0]  DivMTopBit    = 4'd8;
  localparam logic [3:0]  DivYTopBit    = 4'd6;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Leap test on a year held as its residue mod 400.
  function automatic logic leap_of(input logic [8:0] r);
    return (r[1:0] == 2'd0) && !(r == 9'd100 || r == 9'd200 || r == 9'd300);
  endfunction

endpackage

`default_nettype wire

// ===== sv/calendar_date_add_offset.sv =====
// calendar_date_add_offset: Gregorian start date plus year/month/day offsets.
// Depends on cdao_pkg (states, constants, month length lookup).
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: start date and
//   nonnegative offsets. Output channel (out_valid_o / out_ready_i) returns
//   the resulting date, one result per item.
//   The block works on one item at a time; in_ready_o is high only while idle.
//   All arithmetic runs through one 17-bit subtract/compare unit, in steps:
//     load, month carry (restoring divide by 12), year mod 400, then one
//     step per whole year skipped (at most about 180) plus a final check,
//     one step per month advanced (at most 11) plus a final check, and
//     the result is held until taken.
//   The result stays valid and stable while the receiver stalls; no new item
//   is taken until it is accepted.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
//   any item in progress.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_add_offset (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [13:0] start_year_i,
  input  wire logic [3:0]  start_month_i,
  input  wire logic [4:0]  start_day_i,
  input  wire logic [13:0] add_years_i,
  input  wire logic [11:0] add_months_i,
  input  wire logic [15:0] add_days_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [14:0]      result_year_o,
  output logic [3:0]       result_month_o,
  output logic [4:0]       result_day_o
);

  cdao_pkg::state_e state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] y_q, y_d;   // full-width year; leap is decided on its residue r_q
  logic [3:0]  m_q, m_d;
  logic [16:0] d_q, d_d;
  logic [16:0] w_q, w_d;   // division remainder
  logic [8:0]  r_q, r_d;   // year mod 400

  logic [3:0]  sm_fix;
  logic [4:0]  sd_fix;
  logic [8:0]  r_inc;
  logic        feb_leap;
  logic [16:0] span;
  logic [4:0]  mlen;
  logic [16:0] op_a, op_b;
  logic [17:0] diff;
  logic        no_borrow, gt;

  assign sm_fix = (start_month_i == 4'd0) ? cdao_pkg::MonthJan : start_month_i;
  assign sd_fix = (start_day_i == 5'd0) ? 5'd1 : start_day_i;

  assign r_inc = (r_q == 9'(cdao_pkg::LeapCycle - 1)) ? 9'd0 : r_q + 9'd1;
  // Twelve months from (m, y) cover February of y when m <= Feb, else of y+1.
  assign feb_leap = (m_q <= cdao_pkg::MonthFeb) ? cdao_pkg::leap_of(r_q)
                                                : cdao_pkg::leap_of(r_inc);
  assign span = 17'(cdao_pkg::DaysPerYear) + {16'd0, feb_leap};
  assign mlen = cdao_pkg::month_len(m_q, cdao_pkg::leap_of(r_q));

  // Shared subtract/compare unit.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      cdao_pkg::ST_DIVM: begin
        op_a = w_q;
        op_b = 17'(cdao_pkg::MonthsPerYear) << cnt_q;
      end
      cdao_pkg::ST_DIVY: begin
        op_a = w_q;
        op_b = 17'(cdao_pkg::LeapCycle) << cnt_q;
      end
      cdao_pkg::ST_YEARS: begin
        op_a = d_q;
        op_b = span;
      end
      cdao_pkg::ST_MONTHS: begin
        op_a = d_q;
        op_b = {12'd0, mlen};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff      = {1'b0, op_a} - {1'b0, op_b};
  assign no_borrow = !diff[17];
  assign gt        = no_borrow && (diff[16:0] != 17'd0);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    y_d     = y_q;
    m_d     = m_q;
    d_d     = d_q;
    w_d     = w_q;
    r_d     = r_q;
    case (state_q)
      cdao_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          y_d     = {2'd0, start_year_i} + {2'd0, add_years_i};
          w_d     = {4'd0, {9'd0, sm_fix} + {1'b0, add_months_i} - 13'd1};
          d_d     = {12'd0, sd_fix} + {1'b0, add_days_i};
          cnt_d   = cdao_pkg::DivMTopBit;
          state_d = cdao_pkg::ST_DIVM;
        end
      end
      cdao_pkg::ST_DIVM: begin
        if (no_borrow) begin
          w_d = diff[16:0];
          y_d = y_q + (16'd1 << cnt_q);
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          m_d     = w_d[3:0] + 4'd1;
          w_d     = {1'b0, y_d};
          cnt_d   = cdao_pkg::DivYTopBit;
          state_d = cdao_pkg::ST_DIVY;
        end
      end
      cdao_pkg::ST_DIVY: begin
        if (no_borrow) begin
          w_d = diff[16:0];
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          r_d     = w_d[8:0];
          state_d = cdao_pkg::ST_YEARS;
        end
      end
      cdao_pkg::ST_YEARS: begin
        // Day sum beyond the next twelve months: skip a whole year.
        if (gt) begin
          d_d = diff[16:0];
          y_d = y_q + 16'd1;
          r_d = r_inc;
        end else begin
          state_d = cdao_pkg::ST_MONTHS;
        end
      end
      cdao_pkg::ST_MONTHS: begin
        if (gt) begin
          d_d = diff[16:0];
          if (m_q == cdao_pkg::MonthDec) begin
            m_d = cdao_pkg::MonthJan;
            y_d = y_q + 16'd1;
            r_d = r_inc;
          end else begin
            m_d = m_q + 4'd1;
          end
        end else begin
          state_d = cdao_pkg::ST_DONE;
        end
      end
      cdao_pkg::ST_DONE: begin
        if (out_ready_i) begin
          state_d = cdao_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cdao_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdao_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
    m_q <= m_d;
    d_q <= d_d;
    w_q <= w_d;
    r_q <= r_d;
  end

  assign in_ready_o     = (state_q == cdao_pkg::ST_IDLE);
  assign out_valid_o    = (state_q == cdao_pkg::ST_DONE);
  assign result_year_o  = y_q[14:0];
  assign result_month_o = m_q;
  assign result_day_o   = d_q[4:0];

  // Assertions

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_day_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (d_q[16:5] == 12'd0 && d_q[4:0] != 5'd0))
    else $error("result day out of range");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (m_q >= cdao_pkg::MonthJan && m_q <= cdao_pkg::MonthDec))
    else $error("result month out of range");

  a_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cdao_pkg::ST_YEARS || state_q == cdao_pkg::ST_MONTHS)
      |-> (r_q < 9'(cdao_pkg::LeapCycle)))
    else $error("year residue out of range");

  a_day_fits_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (d_q[4:0] <= mlen))
    else $error("result day beyond month length");

endmodule

`default_nettype wire
